>>> rtl/core/bed_pkg.sv
// Shared types, constants and arithmetic helpers for the barycentric embed deform unit.
`default_nettype none
package bed_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int VERTEX_ID_BITS = 16;

    localparam int WORD_W    = 32;
    localparam int ID_W      = 16;
    localparam int PROD_W    = 2 * WORD_W - FRAC_BITS;
    localparam int SUM_W     = PROD_W + 2;
    localparam int N_LANES   = 18;
    localparam int S_TDATA_W = 312;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 1;

    localparam logic [ID_W-1:0] ID_MASK = (VERTEX_ID_BITS >= ID_W) ? {ID_W{1'b1}} :
        ID_W'((64'd1 << VERTEX_ID_BITS) - 64'd1);

    // row select with no matrix row behind it
    localparam logic [1:0] ROW_SPARE = 2'd3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_TRI    = 2'd1,
        FUNC_VERTEX = 2'd2,
        FUNC_SPARE  = 2'd3
    } t_func;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_clamp;

    // full product, arithmetic shift right by FRAC_BITS
    function automatic t_prod mul_shift(input t_word a, input t_word b);
        logic signed [2*WORD_W-1:0] p;
        p = a * b;
        return p[2*WORD_W-1:FRAC_BITS];
    endfunction

    function automatic t_clamp clamp_word(input t_sum s);
        t_clamp r;
        t_sum   hi;
        t_sum   lo;
        hi = SUM_W'(t_word'({1'b0, {(WORD_W-1){1'b1}}}));
        lo = SUM_W'(t_word'({1'b1, {(WORD_W-1){1'b0}}}));
        if (s > hi) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (s < lo) begin
            r.sat = 1'b1;
            r.val = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r.sat = 1'b0;
            r.val = s[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/bed_mul_stage.sv
// Bank of shifted fixed-point multiplier lanes with registered products.
`default_nettype none
module bed_mul_stage (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire bed_pkg::t_word i_a [bed_pkg::N_LANES],
    input  wire bed_pkg::t_word i_b [bed_pkg::N_LANES],
    output bed_pkg::t_prod     o_prod [bed_pkg::N_LANES]
);
    import bed_pkg::*;

    t_prod r_prod [N_LANES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_LANES; l++) begin
                r_prod[l] <= mul_shift(i_a[l], i_b[l]);
            end
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> rtl/core/barycentric_embed_deform_unit.sv
// Top level: triangle affine map builder and embedded vertex deformer.
//
//  channel  | direction | tdata                                | tuser
//  ---------+-----------+--------------------------------------+-------------
//  s        | in        | row_sel, words a..c, nodes, vertex_id | func
//  m        | out       | out_id, out_x, out_y                  | saturated
//
// Three stages: input register, multiplier lane register, result register.
// One item per cycle unless m stalls; a vertex directly behind a triangle
// is held in stage 1 while the triangle's map is written back.
// Load and triangle items give no transfer on m.
// i_rst_n (synchronous) clears matrix, map, flag and all valid bits.
// A stall on m backs up through the stages to o_s_tready.
`default_nettype none
module barycentric_embed_deform_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // row_sel[1:0] word_a[33:2] word_b[65:34] word_c[97:66] node0_x[129:98]
    // node0_y[161:130] node1_x[193:162] node1_y[225:194] node2_x[257:226]
    // node2_y[289:258] vertex_id[305:290], zero pad
    input  wire logic [bed_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[1:0]
    input  wire logic [bed_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // out_id[15:0] out_x[47:16] out_y[79:48]
    output logic [bed_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // saturated[0]
    output logic [bed_pkg::M_TUSER_W-1:0]      o_m_tuser
);
    import bed_pkg::*;

    // stage 1
    logic            r_s1_valid;
    t_func           r_s1_func;
    logic [1:0]      r_s1_row;
    t_word           r_s1_word [3];
    t_word           r_s1_nx [3];
    t_word           r_s1_ny [3];
    logic [ID_W-1:0] r_s1_id;

    // stage 2
    logic            r_s2_valid;
    t_func           r_s2_func;
    logic [ID_W-1:0] r_s2_id;
    t_word           r_s2_base [2];
    logic            r_s2_sat;
    t_prod           s2_prod [N_LANES];

    // held state
    t_word           r_inv [3][3];
    t_word           r_map [2][3];
    logic            r_map_sat;

    // result
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    t_word           r_out_x;
    t_word           r_out_y;
    logic            r_out_sat;

    logic  out_free, s2_adv, s2_free, hazard, s1_adv, s1_free, s_xfer;
    t_word op_a [N_LANES];
    t_word op_b [N_LANES];
    t_word n_map [2][3];
    logic  n_map_sat;
    t_word n_res [2];
    logic  n_res_sat;

    assign out_free = !r_out_valid || i_m_tready;
    assign s2_adv   = r_s2_valid && (r_s2_func != FUNC_VERTEX || out_free);
    assign s2_free  = !r_s2_valid || s2_adv;
    assign hazard   = r_s1_valid && r_s1_func == FUNC_VERTEX &&
                      r_s2_valid && r_s2_func == FUNC_TRI;
    assign s1_adv   = r_s1_valid && s2_free && !hazard;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign o_s_tready = s1_free;
    assign s_xfer   = i_s_tvalid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_s_tvalid;
        end
        if (s_xfer) begin
            r_s1_func <= t_func'(i_s_tuser[1:0]);
            r_s1_row  <= i_s_tdata[1:0];
            for (int i = 0; i < 3; i++) begin
                r_s1_word[i] <= i_s_tdata[2 + WORD_W*i +: WORD_W];
                r_s1_nx[i]   <= i_s_tdata[2 + WORD_W*(3 + 2*i) +: WORD_W];
                r_s1_ny[i]   <= i_s_tdata[2 + WORD_W*(4 + 2*i) +: WORD_W];
            end
            r_s1_id <= i_s_tdata[2 + WORD_W*9 +: ID_W];
        end
    end

    // lane r*9 + c*3 + k: node row r, term k of map column c
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    op_a[r*9 + c*3 + k] = (r == 0) ? r_s1_nx[k] : r_s1_ny[k];
                    op_b[r*9 + c*3 + k] = r_inv[k][c];
                end
            end
        end
        if (r_s1_func == FUNC_VERTEX) begin
            for (int r = 0; r < 2; r++) begin
                op_a[r*9 + 3] = r_map[r][1];
                op_b[r*9 + 3] = r_s1_word[0];
                op_a[r*9 + 6] = r_map[r][2];
                op_b[r*9 + 6] = r_s1_word[1];
            end
        end
    end

    bed_mul_stage u_mul (
        .i_clk  (i_clk),
        .i_en   (s1_adv),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (s2_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_inv[i][j] <= '0;
                end
            end
        end else begin
            if (s1_adv) begin
                r_s2_valid <= r_s1_func == FUNC_TRI || r_s1_func == FUNC_VERTEX;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s1_adv && r_s1_func == FUNC_LOAD && r_s1_row != ROW_SPARE) begin
                for (int j = 0; j < 3; j++) begin
                    r_inv[r_s1_row][j] <= r_s1_word[j];
                end
            end
        end
        if (s1_adv) begin
            r_s2_func    <= r_s1_func;
            r_s2_id      <= r_s1_id & ID_MASK;
            r_s2_base[0] <= r_map[0][0];
            r_s2_base[1] <= r_map[1][0];
            r_s2_sat     <= r_map_sat;
        end
    end

    always_comb begin
        t_clamp cl;
        t_sum   s;
        n_map_sat = 1'b0;
        n_res_sat = r_s2_sat;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 3; c++) begin
                s = SUM_W'(s2_prod[r*9 + c*3]) + SUM_W'(s2_prod[r*9 + c*3 + 1]) +
                    SUM_W'(s2_prod[r*9 + c*3 + 2]);
                cl = clamp_word(s);
                n_map[r][c] = cl.val;
                n_map_sat   = n_map_sat | cl.sat;
            end
            s = SUM_W'(r_s2_base[r]) + SUM_W'(s2_prod[r*9 + 3]) + SUM_W'(s2_prod[r*9 + 6]);
            cl = clamp_word(s);
            n_res[r]  = cl.val;
            n_res_sat = n_res_sat | cl.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_map_sat   <= 1'b0;
            for (int r = 0; r < 2; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_map[r][c] <= '0;
                end
            end
        end else begin
            if (s2_adv && r_s2_func == FUNC_VERTEX) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s2_adv && r_s2_func == FUNC_TRI) begin
                r_map     <= n_map;
                r_map_sat <= n_map_sat;
            end
        end
        if (s2_adv && r_s2_func == FUNC_VERTEX) begin
            r_out_id  <= r_s2_id;
            r_out_x   <= n_res[0];
            r_out_y   <= n_res[1];
            r_out_sat <= n_res_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_y, r_out_x, r_out_id};
    assign o_m_tuser  = r_out_sat;

    a_s2_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_func == FUNC_TRI || r_s2_func == FUNC_VERTEX))
        else $error("stage 2 holds an item that gives nothing");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_s2_valid && r_s2_func == FUNC_VERTEX))
        else $error("result appeared without a vertex in stage 2");

    a_map_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_func == FUNC_TRI) |=> !(r_s2_valid && r_s2_func == FUNC_VERTEX &&
            $past(r_s1_valid && r_s1_func == FUNC_VERTEX && s1_adv)))
        else $error("vertex passed a triangle map still being written");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_s1_valid)
        else $error("input stalled with stage 1 empty");

endmodule
`default_nettype wire
